// ===== design/lxc_pkg.sv =====
// Shared constants, derived widths and the controller/datapath command and
// status structs of the table-keyed chained XOR byte cipher.
// No dependencies; imported by every module of the block.
package lxc_pkg;

  localparam int LUT_ENTRIES = 512;
  localparam int LUT_MAX     = 256;
  localparam int MAX_BYTES   = 64;

  localparam int KEY_AW  = $clog2(LUT_ENTRIES);
  localparam int FILL_W  = $clog2(LUT_ENTRIES + 1);
  localparam int BUF_AW  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int CNT_W   = $clog2(MAX_BYTES + 1);
  localparam int LMAX_W  = $clog2(LUT_MAX + 1);

  localparam int SEED_W    = 31;
  localparam int GEN_MUL_W = 15;
  localparam int PROD_W    = SEED_W + GEN_MUL_W;

  localparam logic [SEED_W-1:0]    GEN_SEED0 = 31'h000a_2c2a;
  localparam logic [GEN_MUL_W-1:0] GEN_MUL   = 15'h41a7;
  localparam logic [SEED_W-1:0]    GEN_MOD   = 31'h7fff_ffff;
  localparam logic [LMAX_W-1:0]    LUT_MAX_C = LMAX_W'(LUT_MAX);

  typedef struct packed {
    logic gen_mul;     // seed * multiplier into the product register
    logic gen_red;     // reduce product mod 2^31-1 into the seed
    logic key_wr;      // scale seed to a key byte and write the table
    logic load;        // store an accepted message word
    logic proc_start;  // message complete: clear chain and byte index
    logic proc;        // run the reverse chaining pass
    logic emit_start;  // clear the output index
    logic emit;        // stream results in original order
    logic msg_end;     // drop the byte count for the next message
  } lxc_cmd_t;

  typedef struct packed {
    logic fill_done;
    logic load_ends;
    logic proc_done;
    logic emit_done;
  } lxc_stat_t;

endpackage

// ===== design/lxc_ctrl.sv =====
// Sequencing controller: key table fill, message load, chaining pass, emit.
// Depends on lxc_pkg for the command and status structs.
module lxc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  lxc_pkg::lxc_stat_t st,
  output lxc_pkg::lxc_cmd_t  cmd
);
  import lxc_pkg::*;

  localparam logic [2:0] S_FMUL = 3'd0;
  localparam logic [2:0] S_FRED = 3'd1;
  localparam logic [2:0] S_FKEY = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_PROC = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_FMUL: begin
        if (st.fill_done) begin
          state_next = S_LOAD;
        end else begin
          cmd.gen_mul = 1'b1;
          state_next  = S_FRED;
        end
      end
      S_FRED: begin
        cmd.gen_red = 1'b1;
        state_next  = S_FKEY;
      end
      S_FKEY: begin
        cmd.key_wr = 1'b1;
        state_next = S_FMUL;
      end
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (st.load_ends) begin
            cmd.proc_start = 1'b1;
            state_next     = S_PROC;
          end
        end
      end
      S_PROC: begin
        cmd.proc = 1'b1;
        if (st.proc_done) begin
          cmd.emit_start = 1'b1;
          state_next     = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (st.emit_done) begin
          cmd.msg_end = 1'b1;
          state_next  = S_LOAD;
        end
      end
      default: begin
        state_next = S_FMUL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FMUL;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== design/lxc_dp.sv =====
// Datapath: key generator, key table and message buffer memories, counters,
// chaining XOR and output register. Depends on lxc_pkg.
module lxc_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  lxc_pkg::lxc_cmd_t cmd,
  output lxc_pkg::lxc_stat_t st,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last
);
  import lxc_pkg::*;

  logic                    direction;
  logic [SEED_W-1:0]       seed;
  logic [PROD_W-1:0]       prod;
  logic [FILL_W-1:0]       fill_idx;
  logic [7:0]              key_mem [LUT_ENTRIES];
  logic [7:0]              ka_q;
  logic [7:0]              kb_q;
  logic [7:0]              buf_mem [MAX_BYTES];
  logic [7:0]              buf_q;
  logic [CNT_W-1:0]        byte_count;
  logic [CNT_W-1:0]        proc_k;
  logic                    pend;
  logic [BUF_AW-1:0]       pend_idx;
  logic [7:0]              chain;
  logic [CNT_W-1:0]        emit_j;
  logic                    out_valid_q;
  logic                    out_last_q;

  // generator reduction: 2^31 == 1 mod 2^31-1
  logic [GEN_MUL_W-1:0]     red_hi;
  logic [SEED_W:0]          red_sum;
  logic [SEED_W:0]          red_val;
  logic [SEED_W-1:0]        seed_red;
  logic [SEED_W-1:0]        seed_next;
  // key scaling: floor(seed * LUT_MAX / (2^31-1))
  logic [SEED_W+LMAX_W-1:0] kx;
  logic [LMAX_W-1:0]        khi;
  logic [SEED_W:0]          ksum;
  logic [LMAX_W-1:0]        kq;
  logic [7:0]               key_val;

  logic                     proc_issue;
  logic [CNT_W-1:0]         proc_pos;
  logic [BUF_AW-1:0]        proc_idx;
  logic [KEY_AW-1:0]        ka_addr;
  logic [KEY_AW-1:0]        kb_addr;
  logic                     emit_adv;
  logic                     buf_ren;
  logic [BUF_AW-1:0]        buf_raddr;
  logic [7:0]               res_byte;
  logic [7:0]               cipher_byte;

  always_comb begin
    red_hi    = prod[PROD_W-1:SEED_W];
    red_sum   = {1'b0, prod[SEED_W-1:0]} + (SEED_W + 1)'(red_hi);
    red_val   = (red_sum >= {1'b0, GEN_MOD}) ? red_sum - {1'b0, GEN_MOD} : red_sum;
    seed_red  = red_val[SEED_W-1:0];
    seed_next = (seed_red == '0) ? SEED_W'(1) : seed_red;

    kx      = {{LMAX_W{1'b0}}, seed} * {{SEED_W{1'b0}}, LUT_MAX_C};
    khi     = kx[SEED_W+LMAX_W-1:SEED_W];
    ksum    = {1'b0, kx[SEED_W-1:0]} + (SEED_W + 1)'(khi);
    kq      = khi + LMAX_W'(ksum >= {1'b0, GEN_MOD});
    key_val = 8'(kq);
  end

  always_comb begin
    proc_issue  = cmd.proc && (proc_k != byte_count);
    proc_pos    = byte_count - CNT_W'(1) - proc_k;
    proc_idx    = BUF_AW'(proc_pos);
    ka_addr     = KEY_AW'({proc_k, 1'b0});
    kb_addr     = KEY_AW'({proc_k, 1'b1});
    emit_adv    = cmd.emit && (emit_j != byte_count) && (!out_valid_q || out_ready);
    buf_ren     = proc_issue || emit_adv;
    buf_raddr   = cmd.emit ? BUF_AW'(emit_j) : proc_idx;
    res_byte    = buf_q ^ ka_q ^ chain;
    cipher_byte = direction ? buf_q : res_byte;
  end

  always_comb begin
    st.fill_done = (fill_idx == FILL_W'(LUT_ENTRIES));
    st.load_ends = last_byte || (byte_count == CNT_W'(MAX_BYTES - 1));
    st.proc_done = (proc_k == byte_count) && !pend;
    st.emit_done = (emit_j == byte_count) && !out_valid_q;
  end

  // key table: one write port for the fill, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.key_wr) begin
      key_mem[fill_idx[KEY_AW-1:0]] <= key_val;
    end
    if (proc_issue) begin
      ka_q <= key_mem[ka_addr];
      kb_q <= key_mem[kb_addr];
    end
  end

  // message buffer: results overwrite their source bytes in place
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      buf_mem[BUF_AW'(byte_count)] <= data_byte;
    end else if (pend) begin
      buf_mem[pend_idx] <= res_byte;
    end
    if (buf_ren) begin
      buf_q <= buf_mem[buf_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.gen_mul) begin
      prod <= {{GEN_MUL_W{1'b0}}, seed} * {{SEED_W{1'b0}}, GEN_MUL};
    end
    if (proc_issue) begin
      pend_idx <= proc_idx;
    end
    if (emit_adv) begin
      out_last_q <= (emit_j == byte_count - CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction   <= 1'b0;
      seed        <= GEN_SEED0;
      fill_idx    <= '0;
      byte_count  <= '0;
      proc_k      <= '0;
      pend        <= 1'b0;
      chain       <= '0;
      emit_j      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        direction <= cfg_wdata;
      end
      if (cmd.gen_red) begin
        seed <= seed_next;
      end
      if (cmd.key_wr) begin
        fill_idx <= fill_idx + FILL_W'(1);
      end
      if (cmd.msg_end) begin
        byte_count <= '0;
      end else if (cmd.load) begin
        byte_count <= byte_count + CNT_W'(1);
      end
      if (cmd.proc_start) begin
        proc_k <= '0;
      end else if (proc_issue) begin
        proc_k <= proc_k + CNT_W'(1);
      end
      pend <= proc_issue;
      if (cmd.proc_start) begin
        chain <= '0;
      end else if (pend) begin
        chain <= cipher_byte ^ kb_q;
      end
      if (cmd.emit_start) begin
        emit_j <= '0;
      end else if (emit_adv) begin
        emit_j <= emit_j + CNT_W'(1);
      end
      if (emit_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_q;
  assign out_byte  = buf_q;
  assign out_last  = out_last_q;

endmodule

// ===== design/lut_xor_chain_cipher_core.sv =====
// Top level of the table-keyed chained XOR byte cipher.
// Instantiates lxc_ctrl and lxc_dp; depends on lxc_pkg.
//
// After reset the block builds a 512-byte key table from a minimal-standard
// multiplicative generator (x * 16807 mod 2^31-1, seed 0xa2c2a), one entry
// at a time through one multiply, one reduce and one scale-and-write step;
// in_ready stays low until the table is full. It then takes message words
// one per cycle into a 64-byte buffer until a word marked last_byte, or
// until the 64th word, which closes the message on its own. The message is
// then chained from its final byte back to its first: each result is the
// byte XOR key[2k] XOR the running chain byte, and the chain takes
// key[2k+1] XOR the ciphertext byte (the result when encrypting, the input
// when decrypting). The pass handles one byte per cycle through the
// registered key and buffer reads. Results are written back in place and
// streamed out in original order, one word per cycle while out_ready is
// high, with out_last on the final one. The block accepts no new word until
// the previous message has fully drained.
// cfg_wdata selects the direction (0 encrypt, 1 decrypt); write it only
// while the block is idle.
module lut_xor_chain_cipher_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import lxc_pkg::*;

  lxc_cmd_t  cmd;
  lxc_stat_t st;

  // sequence fill, load, chaining pass and emit
  lxc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // generator, memories, chain and output register
  lxc_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .data_byte (data_byte),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  // loading and emitting never overlap
  a_no_load_while_emit: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid)
    else $error("input accepted while a result is pending");

  // nothing follows the final word of a message
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("result presented after the final word");

  // a started chaining pass always has at least one byte to process
  a_proc_only_in_pass: assert property (@(posedge clk) disable iff (rst)
    cmd.proc_start |=> !st.proc_done)
    else $error("chaining pass finished with no bytes");

endmodule
